// ----- design/irbda_pkg.sv -----
// Package with shared constants and types of the int8 row-block dot accumulator.
`default_nettype none
package irbda_pkg;

	// Number of columns in one block and the term limit for exact sums.
	localparam int BlockCols = 16;
	localparam int MaxTerms  = 65536;

	// Field and counter widths.
	localparam int ByteW = 8;
	localparam int ProdW = 16;
	localparam int SumW  = 32;
	localparam int ColW  = 4;
	localparam int CntW  = $clog2(MaxTerms + 1);
	localparam int RowsMax = 2;

	typedef logic signed [SumW-1:0] sum_t;
	typedef logic signed [ByteW-1:0] byte_t;

	// Hand-over from the accumulator array to the drain unit.
	typedef struct packed {
		logic load;
		logic two_rows;
		logic too_long;
	} snap_ctl_t;

endpackage
`default_nettype wire

// ----- design/irbda_if.sv -----
// Channel interfaces of the int8 row-block dot accumulator.
`default_nettype none
interface irbda_in_if;
	logic        valid;
	logic        ready;
	logic signed [7:0] left_first;
	logic signed [7:0] left_second;
	logic [63:0] right_low;
	logic [63:0] right_high;
	logic        final_term;

	modport source (output valid, left_first, left_second, right_low, right_high, final_term,
		input ready);
	modport sink (input valid, left_first, left_second, right_low, right_high, final_term,
		output ready);
endinterface

interface irbda_out_if;
	logic        valid;
	logic        ready;
	logic        row_select;
	logic [3:0]  column;
	logic signed [31:0] dot_sum;
	logic        too_long;
	logic        end_of_block;

	modport source (output valid, row_select, column, dot_sum, too_long, end_of_block,
		input ready);
	modport sink (input valid, row_select, column, dot_sum, too_long, end_of_block,
		output ready);
endinterface
`default_nettype wire

// ----- design/irbda_mac_array.sv -----
// Input register, per-column multiply-accumulate lanes and term counter.
`default_nettype none
module irbda_mac_array (
	input  wire logic                clk,
	input  wire logic                arst_n,
	irbda_in_if.sink                 in_ch,
	input  wire logic                two_row_mode,
	input  wire logic                drain_busy,
	output irbda_pkg::snap_ctl_t     snap_ctl,
	output irbda_pkg::sum_t          snap_sums [irbda_pkg::RowsMax*irbda_pkg::BlockCols]
);

	// Input stage registers.
	logic                                    valid_s1;
	irbda_pkg::byte_t                        left_first_s1;
	irbda_pkg::byte_t                        left_second_s1;
	irbda_pkg::byte_t                        right_s1 [irbda_pkg::BlockCols];
	logic                                    final_s1;

	// Accumulator banks and block bookkeeping.
	irbda_pkg::sum_t                         acc_q [irbda_pkg::RowsMax*irbda_pkg::BlockCols];
	logic [irbda_pkg::CntW-1:0]              term_count_q;
	logic                                    overflow_q;

	logic                                    in_accept;
	logic                                    go;
	logic                                    limit_hit;
	logic                                    overflow_next;
	logic [irbda_pkg::CntW-1:0]              term_count_next;
	irbda_pkg::sum_t                         sum_next [irbda_pkg::RowsMax*irbda_pkg::BlockCols];
	logic signed [irbda_pkg::ProdW-1:0]      prod0 [irbda_pkg::BlockCols];
	logic signed [irbda_pkg::ProdW-1:0]      prod1 [irbda_pkg::BlockCols];

	// A final word may only leave the input stage once the drain unit is free.
	assign go           = valid_s1 && (!final_s1 || !drain_busy);
	assign in_ch.ready  = !valid_s1 || go;
	assign in_accept    = in_ch.valid && in_ch.ready;

	// Term counter saturates at the limit; one more term raises the overflow flag.
	assign limit_hit       = (term_count_q >= irbda_pkg::CntW'(irbda_pkg::MaxTerms));
	assign overflow_next   = overflow_q || limit_hit;
	assign term_count_next = limit_hit ? term_count_q : term_count_q + 1'b1;

	// One multiply and one add per lane; the second bank only adds in two-row mode.
	always_comb begin
		for (int c = 0; c < irbda_pkg::BlockCols; c++) begin
			prod0[c] = left_first_s1 * right_s1[c];
			if (two_row_mode) begin
				prod1[c] = left_second_s1 * right_s1[c];
			end else begin
				prod1[c] = '0;
			end
			sum_next[c] = acc_q[c] + irbda_pkg::sum_t'(prod0[c]);
			sum_next[irbda_pkg::BlockCols + c] =
				acc_q[irbda_pkg::BlockCols + c] + irbda_pkg::sum_t'(prod1[c]);
		end
	end

	assign snap_sums         = sum_next;
	assign snap_ctl.load     = go && final_s1;
	assign snap_ctl.two_rows = two_row_mode;
	assign snap_ctl.too_long = overflow_next;

	// Control state and accumulators; the final word clears the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			term_count_q <= '0;
			overflow_q   <= 1'b0;
			for (int i = 0; i < irbda_pkg::RowsMax*irbda_pkg::BlockCols; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				if (final_s1) begin
					term_count_q <= '0;
					overflow_q   <= 1'b0;
					for (int i = 0; i < irbda_pkg::RowsMax*irbda_pkg::BlockCols; i++) begin
						acc_q[i] <= '0;
					end
				end else begin
					term_count_q <= term_count_next;
					overflow_q   <= overflow_next;
					acc_q        <= sum_next;
				end
			end
		end
	end

	// Input payload capture, split into column bytes.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			left_first_s1  <= in_ch.left_first;
			left_second_s1 <= in_ch.left_second;
			final_s1       <= in_ch.final_term;
			for (int c = 0; c < irbda_pkg::BlockCols; c++) begin
				if (c < 8) begin
					right_s1[c] <= in_ch.right_low[c*8 +: 8];
				end else begin
					right_s1[c] <= in_ch.right_high[(c-8)*8 +: 8];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/irbda_drain.sv -----
// Snapshot of finished sums and the output register that sends them one word at a time.
`default_nettype none
module irbda_drain (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire irbda_pkg::snap_ctl_t snap_ctl,
	input  wire irbda_pkg::sum_t     snap_sums [irbda_pkg::RowsMax*irbda_pkg::BlockCols],
	output logic                     busy,
	irbda_out_if.source              out_ch
);

	localparam int Depth = irbda_pkg::RowsMax * irbda_pkg::BlockCols;

	irbda_pkg::sum_t                 snap_q [Depth];
	logic                            busy_q;
	logic [irbda_pkg::ColW-1:0]      col_q;
	logic                            row_q;
	logic                            two_rows_q;
	logic                            too_long_q;
	logic                            out_valid_q;
	logic                            last_word;
	logic                            pop;

	assign busy      = busy_q;
	assign last_word = (col_q == irbda_pkg::ColW'(irbda_pkg::BlockCols - 1)) &&
		(row_q || !two_rows_q);
	assign pop       = busy_q && (!out_valid_q || out_ch.ready);
	assign out_ch.valid = out_valid_q;

	// Sequencing of rows and columns while the snapshot drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= 1'b0;
			two_rows_q  <= 1'b0;
			too_long_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_ctl.load) begin
				busy_q     <= 1'b1;
				col_q      <= '0;
				row_q      <= 1'b0;
				two_rows_q <= snap_ctl.two_rows;
				too_long_q <= snap_ctl.too_long;
			end else if (pop) begin
				if (last_word) begin
					busy_q <= 1'b0;
				end else if (col_q == irbda_pkg::ColW'(irbda_pkg::BlockCols - 1)) begin
					col_q <= '0;
					row_q <= 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Snapshot shifts towards entry zero, which feeds the output register.
	always_ff @(posedge clk) begin
		if (snap_ctl.load) begin
			snap_q <= snap_sums;
		end else if (pop) begin
			for (int i = 0; i < Depth - 1; i++) begin
				snap_q[i] <= snap_q[i+1];
			end
		end
		if (pop) begin
			out_ch.dot_sum      <= snap_q[0];
			out_ch.column       <= col_q;
			out_ch.row_select   <= row_q;
			out_ch.too_long     <= too_long_q;
			out_ch.end_of_block <= last_word;
		end
	end

endmodule
`default_nettype wire

// ----- design/int8_row_block_dot_accumulator.sv -----
// Top level of the int8 row-block dot accumulator.
// A word is registered at the input, then multiplied and accumulated from that register.
// A final word's sums pass through the snapshot register into the output register.
// Throughput: one input word per cycle; a block's 16 or 32 sums leave at one word per
// cycle while the receiver is ready; a later final word waits until that drain ends.
// Reset clears the accumulators, term count, flags and mode register at once.
`default_nettype none
module int8_row_block_dot_accumulator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	irbda_in_if.sink    in_ch,
	irbda_out_if.source out_ch,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata
);

	logic                    two_row_mode_q;
	logic                    drain_busy;
	irbda_pkg::snap_ctl_t    snap_ctl;
	irbda_pkg::sum_t         snap_sums [irbda_pkg::RowsMax*irbda_pkg::BlockCols];

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_row_mode_q <= 1'b0;
		end else if (cfg_we) begin
			two_row_mode_q <= cfg_wdata;
		end
	end

	irbda_mac_array u_mac_array (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.two_row_mode (two_row_mode_q),
		.drain_busy   (drain_busy),
		.snap_ctl     (snap_ctl),
		.snap_sums    (snap_sums)
	);

	irbda_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_ctl  (snap_ctl),
		.snap_sums (snap_sums),
		.busy      (drain_busy),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

// ----- design/irbda_checker.sv -----
// Port checker for the int8 row-block dot accumulator, bound to the top level.
`default_nettype none
module irbda_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        row_select,
	input wire logic [3:0]  column,
	input wire logic [31:0] dot_sum,
	input wire logic        too_long,
	input wire logic        end_of_block
);

	logic out_take;
	assign out_take = out_valid && out_ready;

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dot_sum) && $stable(column))
		else $error("stalled result word changed");

	// The closing word of a block is always the last column.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_take && end_of_block |-> column == 4'(irbda_pkg::BlockCols - 1))
		else $error("end of block on a column other than the last");

	// Within a row, the next word follows straight on with the next column.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !end_of_block && column != 4'(irbda_pkg::BlockCols - 1) |=>
		!out_valid || (column == $past(column) + 4'd1 && row_select == $past(row_select)))
		else $error("column sequence broken");

	// The overflow flag is the same for every word of one block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !end_of_block |=> !out_valid || too_long == $past(too_long))
		else $error("overflow flag changed within a block");

endmodule

bind int8_row_block_dot_accumulator irbda_checker u_irbda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.row_select   (out_ch.row_select),
	.column       (out_ch.column),
	.dot_sum      (out_ch.dot_sum),
	.too_long     (out_ch.too_long),
	.end_of_block (out_ch.end_of_block)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench of the int8 row-block dot accumulator.
module tb_top;

	localparam int CycleLimit   = 300000;
	localparam int SettleCycles = 8;
	localparam int HoldCycles   = 300;
	localparam int SegWords     = 52;
	localparam int NumSegs      = 7;
	localparam int NumDir       = 17;

	// One input word as the sender drives it.
	typedef struct packed {
		irbda_pkg::byte_t left_a;
		irbda_pkg::byte_t left_b;
		logic [63:0]      right_lo;
		logic [63:0]      right_hi;
		logic             fin;
	} dot_word_t;

	// One emitted column sum.
	typedef struct packed {
		logic                       row;
		logic [irbda_pkg::ColW-1:0] col;
		irbda_pkg::sum_t            sum;
		logic                       too_long;
		logic                       eob;
	} sum_rec_t;

	// A row of the directed table is either a word or a mode write.
	typedef enum logic {STEP_WORD, STEP_MODE} step_kind_t;

	typedef struct packed {
		step_kind_t      kind;
		logic            mode;
		dot_word_t       w;
		logic            typed;
		irbda_pkg::sum_t t0;
		irbda_pkg::sum_t t1;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	irbda_in_if  in_ch();
	irbda_out_if out_ch();

	int8_row_block_dot_accumulator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state: both accumulator banks, the term tally and the mode copy.
	irbda_pkg::sum_t            col_acc [irbda_pkg::RowsMax*irbda_pkg::BlockCols];
	logic [irbda_pkg::CntW-1:0] term_tally = '0;
	logic                       tally_overflow = 1'b0;
	logic                       row_mode = 1'b0;
	sum_rec_t                   sums_due [$];

	int          errors = 0;
	bit          gaps_on = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned cycle_count = 0;
	dir_step_t   dir_steps [NumDir];

	// Clock with a period of 20 units.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Folds one accepted word into the predictor and queues the sums it releases.
	task automatic take_word(input dot_word_t w, input logic typed, input irbda_pkg::sum_t t0,
			input irbda_pkg::sum_t t1);
		irbda_pkg::byte_t a0, a1, b;
		sum_rec_t         rec;
		int               rows;
		a0 = w.left_a;
		a1 = w.left_b;
		for (int c = 0; c < irbda_pkg::BlockCols; c++) begin
			b = (c < 8) ? w.right_lo[c*8 +: 8] : w.right_hi[(c-8)*8 +: 8];
			col_acc[c] = col_acc[c] + a0 * b;
			if (row_mode) begin
				col_acc[irbda_pkg::BlockCols + c] = col_acc[irbda_pkg::BlockCols + c] + a1 * b;
			end
		end
		if (term_tally >= irbda_pkg::MaxTerms) begin
			tally_overflow = 1'b1;
		end else begin
			term_tally = term_tally + 1'b1;
		end
		if (!w.fin) return;
		// Emission follows the mode at the final word, first row first.
		rows = row_mode ? 2 : 1;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < irbda_pkg::BlockCols; c++) begin
				rec.row      = r[0];
				rec.col      = irbda_pkg::ColW'(c);
				rec.sum      = typed ? ((r == 1) ? t1 : t0) :
					col_acc[r*irbda_pkg::BlockCols + c];
				rec.too_long = tally_overflow;
				rec.eob      = (r == rows - 1) && (c == irbda_pkg::BlockCols - 1);
				sums_due.push_back(rec);
			end
		end
		foreach (col_acc[i]) col_acc[i] = '0;
		term_tally     = '0;
		tally_overflow = 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input dot_word_t w, input logic typed, input irbda_pkg::sum_t t0,
			input irbda_pkg::sum_t t1);
		in_ch.valid       <= 1'b1;
		in_ch.left_first  <= w.left_a;
		in_ch.left_second <= w.left_b;
		in_ch.right_low   <= w.right_lo;
		in_ch.right_high  <= w.right_hi;
		in_ch.final_term  <= w.fin;
		do @(posedge clk); while (!in_ch.ready);
		take_word(w, typed, t0, t1);
		@(negedge clk);
	endtask

	// Random sender gap with valid low, taken one time in four while gaps are on.
	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	// Stops sending until every sum has arrived and the pipeline has emptied.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sums_due.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we   <= 1'b0;
		row_mode  = m;
	endtask

	// Left bytes lean towards the extremes and zero.
	function automatic irbda_pkg::byte_t pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h00;
			default: return irbda_pkg::byte_t'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] pick_slice();
		case ($urandom_range(0, 7))
			0: return {8{8'h80}};
			1: return {8{8'h7F}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One dot product of random content, closed by its final word.
	task automatic send_rand_block(input int len);
		dot_word_t w;
		for (int k = 0; k < len; k++) begin
			w.left_a   = pick_byte();
			w.left_b   = pick_byte();
			w.right_lo = pick_slice();
			w.right_hi = pick_slice();
			w.fin      = (k == len - 1);
			maybe_gap();
			send_word(w, 1'b0, '0, '0);
		end
	endtask

	// Result checker: every accepted sum against the oldest expectation.
	always @(posedge clk) begin : check_sums
		sum_rec_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.row_select, out_ch.column, out_ch.dot_sum, out_ch.too_long,
				out_ch.end_of_block};
			if (sums_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected sum row %0d col %0d sum %0d too_long %0b end %0b",
					$time, got.row, got.col, got.sum, got.too_long, got.eob);
			end else begin
				want = sums_due.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: expected row %0d col %0d sum %0d too_long %0b end %0b",
						$time, want.row, want.col, want.sum, want.too_long, want.eob);
					$display("%0t: actual   row %0d col %0d sum %0d too_long %0b end %0b",
						$time, got.row, got.col, got.sum, got.too_long, got.eob);
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HoldCycles;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 16);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CycleLimit);
		$display("tb_top failed");
		$finish;
	end

	// Main sequence: directed table, then random segments.
	initial begin : stimulus
		int sent, len;
		foreach (col_acc[i]) col_acc[i] = '0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.left_first  = '0;
		in_ch.left_second = '0;
		in_ch.right_low   = '0;
		in_ch.right_high  = '0;
		in_ch.final_term  = 1'b0;

		// Extremes carry typed sums; mixed rows and mode switches within a block
		// go through the predictor.
		dir_steps = '{
			'{STEP_WORD, 1'b0, '{8'h01, 8'h00, {8{8'h01}}, {8{8'h01}}, 1'b1},
				1'b1, 32'sd1, 32'sd0},
			'{STEP_MODE, 1'b1, '0, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h80, 8'h80, {8{8'h80}}, {8{8'h80}}, 1'b1},
				1'b1, 32'sd16384, 32'sd16384},
			'{STEP_WORD, 1'b0, '{8'h7F, 8'h80, {8{8'h7F}}, {8{8'h7F}}, 1'b1},
				1'b1, 32'sd16129, -32'sd16256},
			'{STEP_WORD, 1'b0, '{8'h80, 8'h7F, {8{8'h80}}, {8{8'h80}}, 1'b1},
				1'b1, 32'sd16384, -32'sd16256},
			'{STEP_WORD, 1'b0, '{8'h7F, 8'h7F, {8{8'h7F}}, {8{8'h7F}}, 1'b1},
				1'b1, 32'sd16129, 32'sd16129},
			'{STEP_WORD, 1'b0, '{8'h00, 8'h00, {8{8'hFF}}, {8{8'hFF}}, 1'b1},
				1'b1, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'hFF, 8'h01, 64'h8001_7FFF_0255_AA7F,
				64'h0FF0_C33C_5AA5_8180, 1'b0}, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h81, 8'h7E, 64'hFEDC_BA98_7654_3210,
				64'h0123_4567_89AB_CDEF, 1'b1}, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h7F, 8'h80, {8{8'hFF}}, {8{8'h01}}, 1'b0},
				1'b0, 32'sd0, 32'sd0},
			'{STEP_MODE, 1'b0, '0, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h03, 8'h05, 64'h7F80_7F80_0102_0304,
				64'hFFFE_FDFC_8081_7E7F, 1'b0}, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h80, 8'h80, 64'h1122_3344_5566_7788,
				64'h99AA_BBCC_DDEE_FF00, 1'b1}, 1'b0, 32'sd0, 32'sd0},
			'{STEP_MODE, 1'b1, '0, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h02, 8'hFD, 64'h8899_AABB_CCDD_EEFF,
				64'h0011_2233_4455_6677, 1'b1}, 1'b0, 32'sd0, 32'sd0},
			'{STEP_MODE, 1'b0, '0, 1'b0, 32'sd0, 32'sd0},
			'{STEP_WORD, 1'b0, '{8'h80, 8'h7F, {8{8'h80}}, {8{8'h80}}, 1'b1},
				1'b1, 32'sd16384, 32'sd0}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == STEP_MODE) begin
				write_mode(dir_steps[i].mode);
			end else begin
				maybe_gap();
				send_word(dir_steps[i].w, dir_steps[i].typed, dir_steps[i].t0,
					dir_steps[i].t1);
			end
		end

		// Random segments under alternating modes; the last runs without gaps.
		for (int seg = 0; seg < NumSegs; seg++) begin
			if (seg == NumSegs - 1) gaps_on = 1'b0;
			write_mode(seg[0]);
			if (seg == 3) begin
				// Long receiver hold-off while blocks keep coming, then a full drain.
				hold_request = 1'b1;
				for (int k = 0; k < 6; k++) send_rand_block($urandom_range(1, 3));
				settle();
			end
			sent = 0;
			while (sent < SegWords) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 6);
				send_rand_block(len);
				sent += len;
			end
		end

		settle();
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/irbda_pkg.sv
design/irbda_if.sv
design/irbda_mac_array.sv
design/irbda_drain.sv
design/int8_row_block_dot_accumulator.sv
design/irbda_checker.sv
sim/tb_top.sv
